>>> hdl/h2r_pkg.sv
`timescale 1ns / 1ps

package h2r_pkg;

    localparam logic [8:0] HUE_MAX    = 9'd359;
    localparam logic [6:0] PCT_MAX    = 7'd100;
    localparam logic [8:0] SECTOR_DEG = 9'd60;
    localparam logic [4:0] FIVE_MAX   = 5'd31;
    localparam logic [5:0] SIX_MAX    = 6'd63;
    localparam int         NUM_STAGES = 8;

    // Reciprocal constants: x / 100 == (x * 10486) >> 20 for x below 43690,
    // x / 3 == (x * 683) >> 11 for x below 2048.
    localparam logic [13:0] RECIP_100 = 14'd10486;
    localparam logic [9:0]  RECIP_3   = 10'd683;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    function automatic logic [6:0] div100(input logic [13:0] x);
        logic [27:0] prod;
        prod = x * RECIP_100;
        return prod[26:20];
    endfunction

    function automatic logic [6:0] div3(input logic [8:0] x);
        logic [18:0] prod;
        prod = x * RECIP_3;
        return prod[17:11];
    endfunction

    function automatic logic [8:0] sector_base(input t_sector sec);
        logic [8:0] base;
        case (sec)
            SEC_0:   base = 9'd0;
            SEC_1:   base = SECTOR_DEG;
            SEC_2:   base = 9'(SECTOR_DEG * 2);
            SEC_3:   base = 9'(SECTOR_DEG * 3);
            SEC_4:   base = 9'(SECTOR_DEG * 4);
            default: base = 9'(SECTOR_DEG * 5);
        endcase
        return base;
    endfunction

endpackage

>>> hdl/hsv_to_rgb565.sv
`timescale 1ns / 1ps

// Converts hue (degrees), saturation and value (percent) into a packed RGB565
// pixel; inputs above range saturate to 359 or 100. The block is an eight-stage
// pipeline that takes one beat per clock unless a stalled output backs up to
// its input, and returns results in order; the depth is set by the chain of
// constant divisions by 100, each a reciprocal multiply in a stage of its own.
// A stalled output holds its beat, and empty stages still fill behind it.
module hsv_to_rgb565 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [8:0]  i_hue,
    input  logic [6:0]  i_saturation,
    input  logic [6:0]  i_brightness,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_pixel_rgb565
);
    import h2r_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_adv;

    // Stage 1: clamp and sector split.
    t_sector     r1_sec;
    logic [5:0]  r1_rem;
    logic [6:0]  r1_sat, r1_val;
    // Stage 2: sector position and floor product.
    t_sector     r2_sec;
    logic [6:0]  r2_frac, r2_sat, r2_val;
    logic [13:0] r2_pfloor;
    // Stage 3: saturation products and floor level.
    t_sector     r3_sec;
    logic [6:0]  r3_val, r3_floor;
    logic [13:0] r3_sf, r3_sr;
    // Stage 4: falling and rising factors.
    t_sector     r4_sec;
    logic [6:0]  r4_val, r4_floor, r4_ft, r4_rt;
    // Stage 5: level products.
    t_sector     r5_sec;
    logic [6:0]  r5_val, r5_floor;
    logic [13:0] r5_pfall, r5_prise;
    // Stage 6: channel levels.
    logic [6:0]  r6_r, r6_g, r6_b;
    // Stage 7: scaled channel products.
    logic [13:0] r7_r, r7_g, r7_b;
    // Stage 8: packed pixel.
    logic [15:0] r8_pix;

    logic [8:0]  w_hue;
    logic [6:0]  w_sat, w_val;
    t_sector     w_sec;
    logic [8:0]  w_rem;
    logic [6:0]  w_fall, w_rise;
    logic [6:0]  w_rc, w_gc, w_bc;
    logic [6:0]  w_ro, w_go, w_bo;

    always_comb begin
        w_adv[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_stall        = !w_adv[0];
    assign o_valid        = r_vld[NUM_STAGES-1];
    assign o_pixel_rgb565 = r8_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        w_hue = (i_hue > HUE_MAX) ? HUE_MAX : i_hue;
        w_sat = (i_saturation > PCT_MAX) ? PCT_MAX : i_saturation;
        w_val = (i_brightness > PCT_MAX) ? PCT_MAX : i_brightness;
        if (w_hue >= 9'(SECTOR_DEG * 5)) begin
            w_sec = SEC_5;
        end else if (w_hue >= 9'(SECTOR_DEG * 4)) begin
            w_sec = SEC_4;
        end else if (w_hue >= 9'(SECTOR_DEG * 3)) begin
            w_sec = SEC_3;
        end else if (w_hue >= 9'(SECTOR_DEG * 2)) begin
            w_sec = SEC_2;
        end else if (w_hue >= SECTOR_DEG) begin
            w_sec = SEC_1;
        end else begin
            w_sec = SEC_0;
        end
        w_rem = w_hue - sector_base(w_sec);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r1_sec <= w_sec;
            r1_rem <= w_rem[5:0];
            r1_sat <= w_sat;
            r1_val <= w_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r2_sec    <= r1_sec;
            r2_frac   <= div3(9'(r1_rem * 3'd5));
            r2_sat    <= r1_sat;
            r2_val    <= r1_val;
            r2_pfloor <= r1_val * (PCT_MAX - r1_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r3_sec   <= r2_sec;
            r3_val   <= r2_val;
            r3_floor <= div100(r2_pfloor);
            r3_sf    <= r2_sat * r2_frac;
            r3_sr    <= r2_sat * (PCT_MAX - r2_frac);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r4_sec   <= r3_sec;
            r4_val   <= r3_val;
            r4_floor <= r3_floor;
            r4_ft    <= PCT_MAX - div100(r3_sf);
            r4_rt    <= PCT_MAX - div100(r3_sr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r5_sec   <= r4_sec;
            r5_val   <= r4_val;
            r5_floor <= r4_floor;
            r5_pfall <= r4_val * r4_ft;
            r5_prise <= r4_val * r4_rt;
        end
    end

    always_comb begin
        w_fall = div100(r5_pfall);
        w_rise = div100(r5_prise);
        case (r5_sec)
            SEC_0: begin
                w_rc = r5_val;   w_gc = w_rise;   w_bc = r5_floor;
            end
            SEC_1: begin
                w_rc = w_fall;   w_gc = r5_val;   w_bc = r5_floor;
            end
            SEC_2: begin
                w_rc = r5_floor; w_gc = r5_val;   w_bc = w_rise;
            end
            SEC_3: begin
                w_rc = r5_floor; w_gc = w_fall;   w_bc = r5_val;
            end
            SEC_4: begin
                w_rc = w_rise;   w_gc = r5_floor; w_bc = r5_val;
            end
            default: begin
                w_rc = r5_val;   w_gc = r5_floor; w_bc = w_fall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r6_r <= w_rc;
            r6_g <= w_gc;
            r6_b <= w_bc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r7_r <= 14'(r6_r * FIVE_MAX);
            r7_g <= 14'(r6_g * SIX_MAX);
            r7_b <= 14'(r6_b * FIVE_MAX);
        end
    end

    always_comb begin
        w_ro = div100(r7_r);
        w_go = div100(r7_g);
        w_bo = div100(r7_b);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[7]) begin
            r8_pix <= {w_ro[4:0], w_go[5:0], w_bo[4:0]};
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import h2r_pkg::*;

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_LIGHT,
        PACE_HEAVY
    } t_pace;

    typedef struct {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] bright;
        int         gap;
    } t_color;

    localparam int HALF_PERIOD = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_COLORS = 1650;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [8:0]  i_hue = '0;
    logic [6:0]  i_saturation = '0;
    logic [6:0]  i_brightness = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_pixel_rgb565;

    t_color      pending_colors[$];
    logic [15:0] expected_pixels[$];
    t_pace       feed_pace = PACE_FULL;
    t_pace       drain_pace = PACE_FULL;
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    int          mismatches = 0;

    hsv_to_rgb565 dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_hue          (i_hue),
        .i_saturation   (i_saturation),
        .i_brightness   (i_brightness),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_rgb565 (o_pixel_rgb565)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int draw_wait(input t_pace pace);
        case (pace)
            PACE_FULL:  return 0;
            PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            default:    return $urandom_range(0, 14);
        endcase
    endfunction

    function automatic logic [15:0] hsv_pixel(input logic [8:0] hue_in,
                                              input logic [6:0] sat_in,
                                              input logic [6:0] val_in);
        int unsigned hue_d;
        int unsigned sat_p;
        int unsigned val_p;
        int unsigned frac;
        int unsigned lv_floor;
        int unsigned lv_fall;
        int unsigned lv_rise;
        int unsigned red;
        int unsigned green;
        int unsigned blue;
        t_sector     sector;
        hue_d = (hue_in > HUE_MAX) ? HUE_MAX : hue_in;
        sat_p = (sat_in > PCT_MAX) ? PCT_MAX : sat_in;
        val_p = (val_in > PCT_MAX) ? PCT_MAX : val_in;
        sector = t_sector'(hue_d / SECTOR_DEG);
        frac = ((hue_d % SECTOR_DEG) * PCT_MAX) / SECTOR_DEG;
        lv_floor = (val_p * (PCT_MAX - sat_p)) / PCT_MAX;
        lv_fall = (val_p * (PCT_MAX - (sat_p * frac) / PCT_MAX)) / PCT_MAX;
        lv_rise = (val_p * (PCT_MAX - (sat_p * (PCT_MAX - frac)) / PCT_MAX)) / PCT_MAX;
        case (sector)
            SEC_0: begin
                red = val_p; green = lv_rise; blue = lv_floor;
            end
            SEC_1: begin
                red = lv_fall; green = val_p; blue = lv_floor;
            end
            SEC_2: begin
                red = lv_floor; green = val_p; blue = lv_rise;
            end
            SEC_3: begin
                red = lv_floor; green = lv_fall; blue = val_p;
            end
            SEC_4: begin
                red = lv_rise; green = lv_floor; blue = val_p;
            end
            default: begin
                red = val_p; green = lv_floor; blue = lv_fall;
            end
        endcase
        red = (red * FIVE_MAX) / PCT_MAX;
        green = (green * SIX_MAX) / PCT_MAX;
        blue = (blue * FIVE_MAX) / PCT_MAX;
        return {red[4:0], green[5:0], blue[4:0]};
    endfunction

    task automatic add_color(input logic [8:0] hue, input logic [6:0] sat,
                             input logic [6:0] bright);
        t_color color;
        color.hue = hue;
        color.sat = sat;
        color.bright = bright;
        color.gap = draw_wait(feed_pace);
        pending_colors.push_back(color);
    endtask

    // The driver moves on once the current beat has been taken, waiting out
    // the gap drawn for it before presenting the next one.
    always @(negedge i_clk) begin
        t_color next_color;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_colors.size() != 0) begin
                next_color = pending_colors.pop_front();
                i_valid <= 1'b1;
                i_hue <= next_color.hue;
                i_saturation <= next_color.sat;
                i_brightness <= next_color.bright;
                gap_left = next_color.gap;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_taken) begin
            stall_left = draw_wait(drain_pace);
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        logic [15:0] want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else if (i_rst_n) begin
            in_taken <= i_valid && !o_stall;
            out_taken <= o_valid && !i_stall;
            if (i_valid && !o_stall) begin
                expected_pixels.push_back(hsv_pixel(i_hue, i_saturation, i_brightness));
            end
            if (o_valid && !i_stall) begin
                results_seen <= results_seen + 1;
                if (results_seen % 100 == 99) begin
                    drain_pace <= t_pace'($urandom_range(0, 2));
                end
                if (expected_pixels.size() == 0) begin
                    $error("pixel_rgb565 without a pending beat: actual %h", o_pixel_rgb565);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_pixel_rgb565 !== want) begin
                        $error("pixel_rgb565 mismatch: expected %h, actual %h",
                               want, o_pixel_rgb565);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

    initial begin
        int unsigned extreme_hue[8];
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] bright;
        extreme_hue = '{0, 59, 60, 179, 180, 300, 359, 511};
        foreach (extreme_hue[k]) begin
            add_color(9'(extreme_hue[k]), 7'd100, 7'd100);
        end
        add_color(9'd119, 7'd100, 7'd100);
        add_color(9'd120, 7'd50, 7'd100);
        add_color(9'd239, 7'd100, 7'd75);
        add_color(9'd240, 7'd100, 7'd100);
        add_color(9'd299, 7'd33, 7'd100);
        add_color(9'd360, 7'd100, 7'd100);
        add_color(9'd30, 7'd0, 7'd100);
        add_color(9'd200, 7'd0, 7'd57);
        add_color(9'd90, 7'd101, 7'd100);
        add_color(9'd150, 7'd127, 7'd80);
        add_color(9'd270, 7'd100, 7'd101);
        add_color(9'd330, 7'd60, 7'd127);
        add_color(9'd45, 7'd100, 7'd0);
        add_color(9'd511, 7'd127, 7'd127);
        add_color(9'd0, 7'd0, 7'd0);
        add_color(9'd256, 7'd64, 7'd1);
        for (int n = 0; n < RANDOM_COLORS; n++) begin
            if (n % 150 == 0) begin
                feed_pace = t_pace'(n / 150 % 3);
            end
            if ($urandom_range(0, 9) == 0) begin
                hue = 9'($urandom);
                sat = 7'($urandom);
                bright = 7'($urandom);
            end else begin
                hue = 9'($urandom_range(0, 359));
                sat = ($urandom_range(0, 7) == 0) ? 7'd100 : 7'($urandom_range(0, 100));
                bright = ($urandom_range(0, 7) == 0) ? 7'd100 : 7'($urandom_range(0, 100));
            end
            add_color(hue, sat, bright);
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_colors.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/h2r_pkg.sv
hdl/hsv_to_rgb565.sv
bench/testbench.sv
